// ===== rtl/core/spherical_quad_cell_area_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spherical quad cell area block
// Shared property forms for the port checker, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_QUAD_CELL_AREA_ASSERT_SVH
`define SPHERICAL_QUAD_CELL_AREA_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SQCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sqca_pkg.sv =====
// ----------------------------------------------------------------------------
// sqca_pkg
// Widths, fixed-point constants and shared types of the cell area pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sqca_pkg;

  localparam int CORDIC_STAGES  = 24;
  localparam int NUM_CORNERS    = 4;
  localparam int LAT_RAD_STAGES = 3;
  localparam int LON_DELAY      = LAT_RAD_STAGES + CORDIC_STAGES;
  localparam int AREA_STAGES    = 8;

  localparam int LON_W      = 27;
  localparam int LAT_W      = 24;
  localparam int CORNER_W   = LON_W + LAT_W;
  localparam int ANG_W      = 34;
  localparam int AREA_W     = 53;
  localparam int RADIUS_W   = 24;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 56;

  // Angles in 1/65536 degree.
  localparam logic signed [LAT_W:0]   QUARTER_TURN = 25'sd5898240;
  localparam logic signed [LON_W:0]   HALF_TURN    = 28'sd11796480;
  localparam logic signed [LON_W:0]   FULL_TURN    = 28'sd23592960;

  // Degrees to Q30 radians: round(mag * PI_Q32 / (45 * 2^20)), with
  // PI_Q32 = 45 * RAD_A + RAD_B split so that only a small value is divided.
  localparam logic [28:0] RAD_A     = 29'd299845282;
  localparam logic [3:0]  RAD_B     = 4'd15;
  localparam logic [26:0] RAD_HALF  = 27'd23592960;
  localparam logic [26:0] RECIP_45  = 27'd95443717;
  localparam logic [26:0] DIV_45    = 27'd45;

  localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic signed [ANG_W-1:0] ATAN_Q30 [32] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128,
    34'sd64,        34'sd32,        34'sd16,        34'sd8,
    34'sd4,         34'sd2,         34'sd1,         34'sd1
  };

  // floor(pi * 2^64 / 360), 58 significant bits.
  localparam logic [63:0] PI_OVER_360_Q64 = 64'hC90FDAA22168C234 / 64'd90;
  localparam logic [57:0] SCALE_C         = PI_OVER_360_Q64[57:0];

  localparam logic [58:0] AREA_LIMIT   = 59'd4000000000000000;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
  localparam logic [R2_W-1:0]     R2_RESET     = 48'd40589641000000;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_t;

endpackage

`default_nettype wire

// ===== rtl/core/sqca_lat_rad.sv =====
// ----------------------------------------------------------------------------
// sqca_lat_rad
// Three-stage conversion of corner latitudes to Q30 radians for the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module sqca_lat_rad (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sqca_pkg::pipe_t                      pipe_i,
  input  logic signed [sqca_pkg::LAT_W-1:0]    lat_i [sqca_pkg::NUM_CORNERS],
  output logic                                 valid_o,
  output logic signed [sqca_pkg::ANG_W-1:0]    z_o   [sqca_pkg::NUM_CORNERS]
);
  import sqca_pkg::*;

  logic [2:0]  v_q;
  logic [51:0] pa_d [NUM_CORNERS];
  logic [26:0] xa_d [NUM_CORNERS];
  logic        na_d [NUM_CORNERS];
  logic [51:0] pa_q [NUM_CORNERS];
  logic [26:0] xa_q [NUM_CORNERS];
  logic        na_q [NUM_CORNERS];
  logic [21:0] eb_d [NUM_CORNERS];
  logic [51:0] pb_q [NUM_CORNERS];
  logic [26:0] xb_q [NUM_CORNERS];
  logic [21:0] eb_q [NUM_CORNERS];
  logic        nb_q [NUM_CORNERS];
  logic signed [ANG_W-1:0] zc_d [NUM_CORNERS];
  logic signed [ANG_W-1:0] zc_q [NUM_CORNERS];

  // Stage A: fold latitudes beyond the poles, split the constant product.
  always_comb begin
    logic signed [LAT_W:0] lat_x;
    logic signed [LAT_W:0] refl;
    logic [22:0]           mag;
    for (int l = 0; l < NUM_CORNERS; l++) begin
      lat_x = (LAT_W+1)'(lat_i[l]);
      if (lat_x > QUARTER_TURN) begin
        refl = (QUARTER_TURN <<< 1) - lat_x;
      end else if (lat_x < -QUARTER_TURN) begin
        refl = -(QUARTER_TURN <<< 1) - lat_x;
      end else begin
        refl = lat_x;
      end
      na_d[l] = refl[LAT_W];
      mag     = refl[LAT_W] ? 23'(-refl) : refl[22:0];
      pa_d[l] = 52'(mag) * 52'(RAD_A);
      xa_d[l] = 27'(27'(mag) * 27'(RAD_B)) + RAD_HALF;
    end
  end

  // Stage B: reciprocal estimate of the small part divided by 45.
  always_comb begin
    logic [53:0] prod;
    for (int l = 0; l < NUM_CORNERS; l++) begin
      prod    = 54'(xa_q[l]) * 54'(RECIP_45);
      eb_d[l] = prod[53:32];
    end
  end

  // Stage C: one correction step, then drop the 2^20 of the divisor.
  always_comb begin
    logic [26:0] rem;
    logic [21:0] quo;
    logic [51:0] tot;
    for (int l = 0; l < NUM_CORNERS; l++) begin
      rem     = xb_q[l] - 27'(27'(eb_q[l]) * DIV_45);
      quo     = (rem >= DIV_45) ? eb_q[l] + 22'd1 : eb_q[l];
      tot     = pb_q[l] + 52'(quo);
      zc_d[l] = nb_q[l] ? -ANG_W'(tot[51:20]) : ANG_W'(tot[51:20]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_i.en) begin
      v_q <= {v_q[1:0], pipe_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en) begin
      for (int l = 0; l < NUM_CORNERS; l++) begin
        pa_q[l] <= pa_d[l];
        xa_q[l] <= xa_d[l];
        na_q[l] <= na_d[l];
        pb_q[l] <= pa_q[l];
        xb_q[l] <= xa_q[l];
        eb_q[l] <= eb_d[l];
        nb_q[l] <= na_q[l];
        zc_q[l] <= zc_d[l];
      end
    end
  end

  assign valid_o = v_q[2];
  assign z_o     = zc_q;

endmodule

`default_nettype wire

// ===== rtl/core/sqca_cordic.sv =====
// ----------------------------------------------------------------------------
// sqca_cordic
// Rotation-mode CORDIC, one register stage per iteration, four lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module sqca_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sqca_pkg::pipe_t                   pipe_i,
  input  logic signed [sqca_pkg::ANG_W-1:0] z_i   [sqca_pkg::NUM_CORNERS],
  output logic                              valid_o,
  output logic signed [sqca_pkg::ANG_W-1:0] sin_o [sqca_pkg::NUM_CORNERS]
);
  import sqca_pkg::*;

  logic [CORDIC_STAGES-1:0] v_q;
  logic signed [ANG_W-1:0] xi [CORDIC_STAGES][NUM_CORNERS];
  logic signed [ANG_W-1:0] yi [CORDIC_STAGES][NUM_CORNERS];
  logic signed [ANG_W-1:0] zi [CORDIC_STAGES][NUM_CORNERS];
  logic signed [ANG_W-1:0] x_q [CORDIC_STAGES][NUM_CORNERS];
  logic signed [ANG_W-1:0] y_q [CORDIC_STAGES][NUM_CORNERS];
  logic signed [ANG_W-1:0] z_q [CORDIC_STAGES][NUM_CORNERS];

  always_comb begin
    for (int l = 0; l < NUM_CORNERS; l++) begin
      xi[0][l] = GAIN_Q30;
      yi[0][l] = '0;
      zi[0][l] = z_i[l];
      for (int s = 1; s < CORDIC_STAGES; s++) begin
        xi[s][l] = x_q[s-1][l];
        yi[s][l] = y_q[s-1][l];
        zi[s][l] = z_q[s-1][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_i.en) begin
      v_q <= {v_q[CORDIC_STAGES-2:0], pipe_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en) begin
      for (int s = 0; s < CORDIC_STAGES; s++) begin
        for (int l = 0; l < NUM_CORNERS; l++) begin
          if (!zi[s][l][ANG_W-1]) begin
            x_q[s][l] <= xi[s][l] - (yi[s][l] >>> s);
            y_q[s][l] <= yi[s][l] + (xi[s][l] >>> s);
            z_q[s][l] <= zi[s][l] - ATAN_Q30[s];
          end else begin
            x_q[s][l] <= xi[s][l] + (yi[s][l] >>> s);
            y_q[s][l] <= yi[s][l] - (xi[s][l] >>> s);
            z_q[s][l] <= zi[s][l] + ATAN_Q30[s];
          end
        end
      end
    end
  end

  assign valid_o = v_q[CORDIC_STAGES-1];
  assign sin_o   = y_q[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/sqca_area_scale.sv =====
// ----------------------------------------------------------------------------
// sqca_area_scale
// Edge sum, solid angle and radius scaling in eight register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sqca_area_scale (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sqca_pkg::pipe_t                      pipe_i,
  input  logic signed [sqca_pkg::LON_W-1:0]    lon_i [sqca_pkg::NUM_CORNERS],
  input  logic signed [sqca_pkg::ANG_W-1:0]    sin_i [sqca_pkg::NUM_CORNERS],
  input  logic [sqca_pkg::R2_W-1:0]            r2_i,
  output logic                                 valid_o,
  output logic signed [sqca_pkg::AREA_W-1:0]   area_o
);
  import sqca_pkg::*;

  logic [AREA_STAGES-1:0] v_q;
  logic signed [LON_W:0]   d_d  [NUM_CORNERS];
  logic signed [ANG_W:0]   ss_d [NUM_CORNERS];
  logic signed [LON_W:0]   d_q  [NUM_CORNERS];
  logic signed [ANG_W:0]   ss_q [NUM_CORNERS];
  logic signed [62:0]      p_q  [NUM_CORNERS];
  logic signed [64:0]      sum_q;
  logic [61:0]             mag_q;
  logic                    pos4_q, pos5_q, pos6_q, pos7_q;
  logic [59:0]             pp5_q [4];
  logic [49:0]             om_d, om_q;
  logic [48:0]             pp7_q [4];
  logic signed [AREA_W-1:0] area_d, area_q;
  logic [119:0]            prod1;
  logic [98:0]             prod2;
  logic [58:0]             amag;

  // Edge steps with a single half-turn wrap, and sine pair sums.
  always_comb begin
    logic signed [LON_W:0] d;
    for (int e = 0; e < NUM_CORNERS; e++) begin
      d = (LON_W+1)'(lon_i[(e + 1) % NUM_CORNERS]) - (LON_W+1)'(lon_i[e]);
      if (d > HALF_TURN) begin
        d = d - FULL_TURN;
      end
      if (d < -HALF_TURN) begin
        d = d + FULL_TURN;
      end
      d_d[e]  = d;
      ss_d[e] = (ANG_W+1)'(sin_i[(e + 1) % NUM_CORNERS]) + (ANG_W+1)'(sin_i[e]);
    end
  end

  always_comb begin
    prod1 = (120'(pp5_q[3]) << 60) + (120'(pp5_q[2]) << 31)
          + (120'(pp5_q[1]) << 29) + 120'(pp5_q[0]) + (120'(1) << 69);
    om_d  = prod1[119:70];
    prod2 = (99'(pp7_q[3]) << 49) + (99'(pp7_q[2]) << 25)
          + (99'(pp7_q[1]) << 24) + 99'(pp7_q[0]) + (99'(1) << 39);
    amag  = prod2[98:40];
    if (amag > AREA_LIMIT) begin
      amag = AREA_LIMIT;
    end
    area_d = pos7_q ? -AREA_W'(amag) : AREA_W'(amag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_i.en) begin
      v_q <= {v_q[AREA_STAGES-2:0], pipe_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en) begin
      for (int e = 0; e < NUM_CORNERS; e++) begin
        d_q[e]  <= d_d[e];
        ss_q[e] <= ss_d[e];
        p_q[e]  <= 63'(d_q[e]) * 63'(ss_q[e]);
      end
      sum_q  <= 65'(p_q[0]) + 65'(p_q[1]) + 65'(p_q[2]) + 65'(p_q[3]);
      pos4_q <= (sum_q > 65'sd0);
      mag_q  <= sum_q[64] ? 62'(-sum_q) : sum_q[61:0];
      // mag * C as four partial products: index bit 1 = high half of mag.
      pp5_q[0] <= 60'(mag_q[30:0])  * 60'(SCALE_C[28:0]);
      pp5_q[1] <= 60'(mag_q[30:0])  * 60'(SCALE_C[57:29]);
      pp5_q[2] <= 60'(mag_q[61:31]) * 60'(SCALE_C[28:0]);
      pp5_q[3] <= 60'(mag_q[61:31]) * 60'(SCALE_C[57:29]);
      pos5_q   <= pos4_q;
      om_q     <= om_d;
      pos6_q   <= pos5_q;
      // omega * R^2 the same way: index bit 1 = high half of omega.
      pp7_q[0] <= 49'(om_q[24:0])  * 49'(r2_i[23:0]);
      pp7_q[1] <= 49'(om_q[24:0])  * 49'(r2_i[47:24]);
      pp7_q[2] <= 49'(om_q[49:25]) * 49'(r2_i[23:0]);
      pp7_q[3] <= 49'(om_q[49:25]) * 49'(r2_i[47:24]);
      pos7_q   <= pos6_q;
      area_q   <= area_d;
    end
  end

  assign valid_o = v_q[AREA_STAGES-1];
  assign area_o  = area_q;

endmodule

`default_nettype wire

// ===== rtl/core/spherical_quad_cell_area.sv =====
// ----------------------------------------------------------------------------
// spherical_quad_cell_area
// Signed area of a quadrilateral grid cell on a sphere, one cell per clock.
// ----------------------------------------------------------------------------
// The slave stream carries one request per cell: four corners, each a
// longitude and a latitude in 1/65536 degree. The master stream returns the
// signed cell area in square meters, saturated at +/-4e15.
// The sphere radius is written through cfg_we_i/cfg_wdata_i while the block
// is idle; the user must keep to this, as the block does not enforce it. The
// radius is registered, then its square from it. The pipeline runs the
// degree-to-radian conversion, 24 CORDIC iterations (one register each, four
// latitude lanes in parallel), then the edge sum and split scaling multiplies.
// Throughput is one cell per cycle. The whole pipeline advances on one
// enable: when the output register holds a result the receiver has not
// taken, every stage holds and s_axis_tready drops, so nothing is lost or
// repeated. With the output empty or being taken, a request enters every
// cycle. Reset clears all valid bits and loads the radius of 6371000 m.
// ----------------------------------------------------------------------------
`default_nettype none

module spherical_quad_cell_area (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request, from bit 0: lon_a, lat_a, lon_b, lat_b, lon_c, lat_c, lon_d,
  // lat_d, then zero padding.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sqca_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Result, from bit 0: cell_area, then zero padding.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sqca_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [sqca_pkg::RADIUS_W-1:0]       cfg_wdata_i
);
  import sqca_pkg::*;

  logic                    adv;
  pipe_t                   lat_pipe, cor_pipe, area_pipe;
  logic                    lat_valid, cor_valid, area_valid;
  logic [RADIUS_W-1:0]     radius_q;
  logic [R2_W-1:0]         r2_q;
  logic signed [LON_W-1:0] lon_in [NUM_CORNERS];
  logic signed [LAT_W-1:0] lat_in [NUM_CORNERS];
  logic signed [LON_W-1:0] lon_q  [LON_DELAY][NUM_CORNERS];
  logic signed [ANG_W-1:0] z_w    [NUM_CORNERS];
  logic signed [ANG_W-1:0] sin_w  [NUM_CORNERS];
  logic signed [AREA_W-1:0] area_w;

  // The whole pipeline moves unless a finished result is being held.
  assign adv           = !area_valid || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      lon_in[k] = s_axis_tdata[k*CORNER_W +: LON_W];
      lat_in[k] = s_axis_tdata[k*CORNER_W + LON_W +: LAT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      r2_q     <= R2_RESET;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      r2_q <= R2_W'(radius_q) * R2_W'(radius_q);
    end
  end

  // Longitudes wait alongside the sine computation.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        lon_q[0][k] <= lon_in[k];
        for (int s = 1; s < LON_DELAY; s++) begin
          lon_q[s][k] <= lon_q[s-1][k];
        end
      end
    end
  end

  assign lat_pipe  = '{en: adv, valid: s_axis_tvalid};
  assign cor_pipe  = '{en: adv, valid: lat_valid};
  assign area_pipe = '{en: adv, valid: cor_valid};

  sqca_lat_rad u_lat_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pipe_i  (lat_pipe),
    .lat_i   (lat_in),
    .valid_o (lat_valid),
    .z_o     (z_w)
  );

  sqca_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pipe_i  (cor_pipe),
    .z_i     (z_w),
    .valid_o (cor_valid),
    .sin_o   (sin_w)
  );

  sqca_area_scale u_area (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pipe_i  (area_pipe),
    .lon_i   (lon_q[LON_DELAY-1]),
    .sin_i   (sin_w),
    .r2_i    (r2_q),
    .valid_o (area_valid),
    .area_o  (area_w)
  );

  assign m_axis_tvalid = area_valid;
  assign m_axis_tdata  = {(OUT_DATA_W-AREA_W)'(0), area_w};

endmodule

`default_nettype wire

// ===== rtl/core/sqca_checker.sv =====
// ----------------------------------------------------------------------------
// sqca_checker
// Port-level assertions for the cell area block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spherical_quad_cell_area_assert.svh"

module sqca_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sqca_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import sqca_pkg::*;

  localparam logic signed [AREA_W-1:0] LIMIT_S = 53'sd4000000000000000;

  logic signed [AREA_W-1:0] area_w;
  assign area_w = m_axis_tdata[AREA_W-1:0];

  // A held result keeps its value until taken.
  `SQCA_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  // With the output free, the pipeline must take requests.
  `SQCA_ASSERT_IMP(a_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready, "ready low with output free")
  `SQCA_ASSERT_IMP(a_pad, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:AREA_W] == '0, "padding bits set")
  `SQCA_ASSERT_IMP(a_range, m_axis_tvalid, (area_w <= LIMIT_S) && (area_w >= -LIMIT_S), "area out of range")

endmodule

bind spherical_quad_cell_area sqca_checker u_sqca_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Cell area stream testbench
// Sends quadrilateral cells to spherical_quad_cell_area under several radius
// settings and random idling on both streams. Every returned area is checked
// against a bit-exact fixed-point predictor kept inside this bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIMIT_CYCLES = 600000;
  localparam longint      PI_Q32       = 64'd13493037705;
  localparam longint      RAD_DIV      = 64'd47185920;    // 180 * 2^18
  localparam longint      QTURN        = 64'd5898240;     // 90 degrees
  localparam longint      HTURN        = 64'd11796480;    // 180 degrees
  localparam longint      FTURN        = 64'd23592960;    // 360 degrees
  localparam longint      LON_MAX      = 64'd47185920;
  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [63:0] AREA_MAX     = 64'd4000000000000000;

  typedef struct {
    logic signed [26:0] lon [4];
    logic signed [23:0] lat [4];
  } cell_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [sqca_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [sqca_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [sqca_pkg::RADIUS_W-1:0] cfg_wdata_i = '0;

  // Predictor state: the radius the block holds and the fixed-point tables.
  logic [23:0] radius_m = 24'd6371000;
  longint atan_tab [32];
  longint cordic_gain;
  logic [63:0] deg_scale;

  cell_t pending_cells [$];
  logic signed [52:0] area_q [$];
  cell_t offered_cell;
  int gap_left = 0;
  int stall_left = 0;
  bit steady_send = 1'b0;
  bit steady_take = 1'b0;
  bit pressure_done = 1'b0;
  int n_requests = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 0;
  int cycles = 0;

  spherical_quad_cell_area dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] int_sqrt(logic [63:0] k);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > k) b = b >> 2;
    while (b != 0) begin
      if (k >= r + b) begin
        k = k - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Arctangent table from the Taylor series in Q62, rounded to Q30, and the
  // CORDIC gain from its square in Q62.
  function automatic void build_tables();
    logic [63:0] v;
    logic [63:0] t;
    logic [63:0] g;
    int sh;
    atan_tab[0] = longint'((PI_Q60 + (64'd1 << 31)) >> 32);
    for (int i = 1; i < 32; i++) begin
      v = 0;
      for (int k = 0; ; k++) begin
        sh = i * (2 * k + 1);
        if (sh > 62) break;
        t = ((64'd1 << 62) >> sh) / (2 * k + 1);
        if (k % 2 == 1) v = v - t;
        else v = v + t;
      end
      atan_tab[i] = longint'((v + (64'd1 << 31)) >> 32);
    end
    g = 64'd1 << 62;
    for (int i = 0; i < sqca_pkg::CORDIC_STAGES && i < 32; i++)
      g = g - g / ((64'd1 << (2 * i)) + 1);
    cordic_gain = longint'((int_sqrt(g) + 1) >> 1);
    deg_scale = (PI_Q60 << 2) / 90;
  endfunction

  function automatic longint lat_sine(longint lat);
    longint x;
    longint y;
    longint z;
    longint mag;
    longint dx;
    longint dy;
    bit neg;
    // Latitudes past a pole are reflected back into the quarter turn.
    if (lat > QTURN) lat = 2 * QTURN - lat;
    else if (lat < -QTURN) lat = -2 * QTURN - lat;
    neg = lat < 0;
    mag = neg ? -lat : lat;
    z = (mag * PI_Q32 + RAD_DIV / 2) / RAD_DIV;
    if (neg) z = -z;
    x = cordic_gain;
    y = 0;
    for (int i = 0; i < sqca_pkg::CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tab[i];
      end
    end
    return y;
  endfunction

  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic signed [52:0] predict_area(cell_t c, logic [23:0] r);
    longint lon [4];
    longint sn [4];
    longint sum;
    longint d;
    logic [63:0] mag;
    logic [63:0] omega;
    logic [63:0] a;
    logic [63:0] area;
    int j;
    sum = 0;
    for (int e = 0; e < 4; e++) begin
      lon[e] = longint'(c.lon[e]);
      sn[e] = lat_sine(longint'(c.lat[e]));
    end
    for (int e = 0; e < 4; e++) begin
      j = (e + 1) % 4;
      d = lon[j] - lon[e];
      if (d != 0) begin
        // One wrap only; steps still past half a turn are kept as they are.
        if (d > HTURN) d = d - FTURN;
        if (d < -HTURN) d = d + FTURN;
        sum = sum + d * (sn[j] + sn[e]);
      end
    end
    mag = (sum < 0) ? -sum : sum;
    omega = mul_round(mag, deg_scale, 70);
    a = mul_round(omega, 64'(r) * 64'(r), 40);
    if (a > AREA_MAX) a = AREA_MAX;
    area = (sum > 0) ? -a : a;
    return area[52:0];
  endfunction

  function automatic logic [sqca_pkg::IN_DATA_W-1:0] pack_cell(cell_t c);
    return {4'b0, c.lat[3], c.lon[3], c.lat[2], c.lon[2],
            c.lat[1], c.lon[1], c.lat[0], c.lon[0]};
  endfunction

  // ---------------------------------------------------------------- driver
  // Requests leave the pending queue with random gaps; a request stays on the
  // bus until the block takes it, and its expected area is formed right then.
  always @(posedge clk_i or negedge rst_ni) begin
    bit next_valid;
    int r;
    int gap;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      gap = gap_left;
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        area_q.push_back(predict_area(offered_cell, radius_m));
        n_requests++;
        next_valid = 1'b0;
        if (!steady_send) begin
          r = $urandom_range(0, 99);
          gap = (r < 60) ? 0 : (r < 92) ? int'($urandom_range(1, 3))
                                        : int'($urandom_range(8, 40));
        end
      end
      if (!next_valid) begin
        if (gap > 0) begin
          gap = gap - 1;
        end else if (pending_cells.size() > 0) begin
          offered_cell = pending_cells.pop_front();
          s_axis_tdata <= pack_cell(offered_cell);
          next_valid = 1'b1;
        end
      end
      gap_left <= gap;
      s_axis_tvalid <= next_valid;
    end
  end

  // ---------------------------------------------------------------- receiver
  // Random stalls, plus one long hold-off so the pipeline fills and the block
  // must drop s_axis_tready while requests keep coming.
  always @(posedge clk_i or negedge rst_ni) begin
    int r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!pressure_done && n_requests >= 150) begin
      pressure_done <= 1'b1;
      stall_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (steady_take) begin
      m_axis_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  always @(posedge clk_i) begin
    logic signed [52:0] want;
    logic signed [52:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got = m_axis_tdata[52:0];
      if (area_q.size() == 0) begin
        report_mismatch($sformatf("area %0d with no request outstanding", got));
      end else begin
        want = area_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("cell_area got %0d expected %0d", got, want));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic cell_t make_cell(longint la, longint pa, longint lb, longint pb,
                                      longint lc, longint pc, longint ld, longint pd);
    cell_t c;
    c.lon[0] = 27'(la); c.lat[0] = 24'(pa); c.lon[1] = 27'(lb); c.lat[1] = 24'(pb);
    c.lon[2] = 27'(lc); c.lat[2] = 24'(pc); c.lon[3] = 27'(ld); c.lat[3] = 24'(pd);
    return c;
  endfunction

  // Mostly well-formed cells around a random center, some fully random
  // words that cover every bit of every field, including values past the
  // nominal ranges.
  function automatic cell_t random_cell();
    cell_t c;
    longint lo0;
    longint la0;
    longint w;
    longint h;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      for (int i = 0; i < 4; i++) begin
        c.lon[i] = 27'($urandom);
        c.lat[i] = 24'($urandom);
      end
    end else if (r < 25) begin
      for (int i = 0; i < 4; i++) begin
        c.lon[i] = 27'(longint'($urandom_range(0, 2 * 47185920)) - LON_MAX);
        c.lat[i] = 24'(longint'($urandom_range(0, 2 * 5898240)) - QTURN);
      end
    end else begin
      lo0 = longint'($urandom_range(0, 2 * 47185920)) - LON_MAX;
      la0 = longint'($urandom_range(0, 2 * 5898240)) - QTURN;
      w = (r < 80) ? $urandom_range(1, 65536 * 4) : $urandom_range(1, 65536 * 200);
      h = (r < 80) ? $urandom_range(1, 65536 * 4) : $urandom_range(1, 65536 * 90);
      if (la0 + h > QTURN) la0 = QTURN - h;
      if (lo0 + w > LON_MAX) lo0 = LON_MAX - w;
      if ($urandom_range(0, 1)) begin
        c = make_cell(lo0, la0, lo0 + w, la0, lo0 + w, la0 + h, lo0, la0 + h);
      end else begin
        c = make_cell(lo0, la0, lo0, la0 + h, lo0 + w, la0 + h, lo0 + w, la0);
      end
    end
    return c;
  endfunction

  task automatic write_radius(logic [23:0] r);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    radius_m = r;
    n_settings++;
    // The block registers the radius, then the squared radius from it.
    repeat (3) @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_cells.size() > 0 || s_axis_tvalid || area_q.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_random(int count, bit steady);
    steady_send = steady;
    steady_take = steady;
    for (int i = 0; i < count; i++) pending_cells.push_back(random_cell());
    drain();
  endtask

  initial begin
    longint one;
    build_tables();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    n_settings = 1;
    one = 65536;

    // Directed cells at the reset radius.
    pending_cells.push_back(make_cell(0, 0, 0, 0, 0, 0, 0, 0));
    pending_cells.push_back(make_cell(0, 0, one, 0, one, one, 0, one));
    pending_cells.push_back(make_cell(0, one, one, one, one, 0, 0, 0));
    pending_cells.push_back(make_cell(-LON_MAX, -QTURN, LON_MAX, -QTURN,
                                      LON_MAX, QTURN, -LON_MAX, QTURN));
    // Edges crossing the date line, wrapped once.
    pending_cells.push_back(make_cell(170 * one, 0, -170 * one, 0,
                                      -170 * one, 10 * one, 170 * one, 10 * one));
    pending_cells.push_back(make_cell(-180 * one, 0, 180 * one, 0,
                                      180 * one, one, -180 * one, one));
    // Corners more than a full turn apart keep their excess step.
    pending_cells.push_back(make_cell(-LON_MAX, 0, LON_MAX, 5 * one,
                                      LON_MAX, 45 * one, -LON_MAX, 60 * one));
    pending_cells.push_back(make_cell(-67108864, -8388608, 67108863, 8388607,
                                      -67108864, 8388607, 67108863, -8388608));
    // Latitudes past the poles, reflected before the sine.
    pending_cells.push_back(make_cell(0, 8388607, 10 * one, 8388607,
                                      10 * one, -8388608, 0, -8388608));
    pending_cells.push_back(make_cell(0, 100 * one, 30 * one, 100 * one,
                                      30 * one, 80 * one, 0, 80 * one));
    pending_cells.push_back(make_cell(5, QTURN, 5, QTURN, 6, QTURN, 6, QTURN));
    pending_cells.push_back(make_cell(1, -1, 2, -1, 2, 1, 1, 1));
    drain();

    run_random(300, 1'b0);

    // Largest radius; far-apart corners now run into saturation.
    write_radius(24'hFFFFFF);
    pending_cells.push_back(make_cell(-LON_MAX, -QTURN, LON_MAX, QTURN,
                                      -LON_MAX, QTURN, LON_MAX, -QTURN));
    pending_cells.push_back(make_cell(-67108864, 0, 67108863, 8388607,
                                      67108863, 8388607, -67108864, 0));
    pending_cells.push_back(make_cell(-67108864, 0, -67108864, 8388607,
                                      67108863, 8388607, 67108863, 0));
    run_random(200, 1'b0);

    write_radius(24'd1);
    run_random(150, 1'b1);

    write_radius(24'd0);
    run_random(60, 1'b0);

    write_radius(24'd6371000);
    run_random(250, 1'b0);

    write_radius(24'($urandom_range(1, 16777215)));
    run_random(170, 1'b1);

    $display("Covered %0d cell requests and %0d area results over %0d radius settings,",
             n_requests, n_results, n_settings);
    $display("with random idling on both streams and one long output hold-off.");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sqca_pkg.sv
rtl/core/sqca_lat_rad.sv
rtl/core/sqca_cordic.sv
rtl/core/sqca_area_scale.sv
rtl/core/spherical_quad_cell_area.sv
rtl/core/sqca_checker.sv
bench/tb_top.sv
